[hdl/gdr_pkg.sv]
package gdr_pkg;

  localparam int MAP_SIDE   = 64;
  localparam int MAP_BITS   = 6;
  localparam int MAP_DEPTH  = MAP_SIDE * MAP_SIDE;
  localparam int ADDR_BITS  = 2 * MAP_BITS;
  localparam int SCREEN_COLUMNS = 1024;
  localparam int COL_BITS   = 10;
  localparam int STEP_LIMIT = 2 * MAP_SIDE;
  localparam int STEP_BITS  = 8;
  localparam int DIST_BITS  = 24;
  localparam int SIDE_BITS  = 40;
  localparam logic [7:0] CODE_EMPTY = 8'h30;
  localparam logic [7:0] CODE_OPEN  = 8'h38;

  localparam logic [2:0] REG_PLAYER_X = 3'd0;
  localparam logic [2:0] REG_PLAYER_Y = 3'd1;
  localparam logic [2:0] REG_DIR_X    = 3'd2;
  localparam logic [2:0] REG_DIR_Y    = 3'd3;
  localparam logic [2:0] REG_PLANE_X  = 3'd4;
  localparam logic [2:0] REG_PLANE_Y  = 3'd5;

  // divider request/response
  typedef struct packed {
    logic        start;
    logic [18:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [32:0] quotient;
  } div_rsp_t;

endpackage

[hdl/gdr_ram.sv]
module gdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[hdl/gdr_div.sv]
// 2^32 / divisor, restoring, one quotient bit per cycle (34 iterations)
module gdr_div import gdr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [5:0]  count;
  logic        busy;
  logic        done;
  logic [33:0] num;
  logic [19:0] rem;
  logic [18:0] dvs;
  logic [32:0] quo;
  logic [19:0] trial;

  assign trial = {rem[18:0], num[33]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= 6'd0;
        num   <= {1'b0, 1'b1, 32'd0};
        rem   <= '0;
        dvs   <= req.divisor;
      end else if (busy) begin
        num <= {num[32:0], 1'b0};
        if (trial >= {1'b0, dvs}) begin
          rem <= trial - {1'b0, dvs};
          quo <= {quo[31:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[31:0], 1'b0};
        end
        count <= count + 6'd1;
        if (count == 6'd33) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

[hdl/grid_dda_ray_caster.sv]
// Map write: stores the cell code, no result. Cast: setup states (column, ray,
// magnitude), each reciprocal on one shared divider (skipped when the
// component is zero), then per DDA step the states step, map read and check,
// up to 2*MAP_SIDE steps, then the output state.
// One cast at a time; a pending result only holds the next cast at output.
// rst (synchronous) clears control state and the configuration registers; map stays undefined.
module grid_dda_ray_caster import gdr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: action, cell_row, cell_col, cell_code, screen_col, pad
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,
  // m_tdata: ray_col, wall_distance, hit_side, hit_x, hit_y, hit_code,
  // walk_fault
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [21:0] cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CX    = 4'd1;
  localparam logic [3:0] S_RAY   = 4'd2;
  localparam logic [3:0] S_DIVX  = 4'd3;
  localparam logic [3:0] S_WAITX = 4'd4;
  localparam logic [3:0] S_DIVY  = 4'd5;
  localparam logic [3:0] S_WAITY = 4'd6;
  localparam logic [3:0] S_SIDEX = 4'd7;
  localparam logic [3:0] S_SIDEY = 4'd8;
  localparam logic [3:0] S_STEP  = 4'd9;
  localparam logic [3:0] S_READ  = 4'd10;
  localparam logic [3:0] S_CHECK = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;
  localparam logic [3:0] S_MAG   = 4'd13;

  logic [3:0] state;

  logic [21:0] player_x, player_y;
  logic signed [17:0] dir_x, dir_y, plane_x, plane_y;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      player_x <= '0; player_y <= '0;
      dir_x <= '0; dir_y <= '0; plane_x <= '0; plane_y <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PLAYER_X: player_x <= cfg_data;
        REG_PLAYER_Y: player_y <= cfg_data;
        REG_DIR_X:    dir_x <= cfg_data[17:0];
        REG_DIR_Y:    dir_y <= cfg_data[17:0];
        REG_PLANE_X:  plane_x <= cfg_data[17:0];
        REG_PLANE_Y:  plane_y <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  // input unpack
  logic        in_action;
  logic [5:0]  in_row, in_col;
  logic [7:0]  in_code;
  logic [9:0]  in_scol;
  assign in_action = s_tdata[0];
  assign in_row    = s_tdata[6:1];
  assign in_col    = s_tdata[12:7];
  assign in_code   = s_tdata[20:13];
  assign in_scol   = s_tdata[30:21];

  assign s_tready = (state == S_IDLE);
  logic accept;
  assign accept = s_tvalid && s_tready;

  // map memory
  logic            ram_we;
  logic [ADDR_BITS-1:0] ram_raddr;
  logic [7:0]      ram_rdata;
  logic signed [7:0] mx, my;
  assign ram_we = accept && !in_action;
  assign ram_raddr = {my[MAP_BITS-1:0], mx[MAP_BITS-1:0]};

  gdr_ram #(.WIDTH(8), .DEPTH(MAP_DEPTH)) u_map (
    .clk(clk), .we(ram_we), .waddr({in_row, in_col}), .wdata(in_code),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // shared reciprocal unit
  div_req_t dreq;
  div_rsp_t drsp;
  gdr_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic [9:0]  col;
  logic signed [17:0] cx;
  logic signed [35:0] prod_x, prod_y;
  logic signed [19:0] ray_x, ray_y;
  logic [18:0] mag_x, mag_y;
  logic        fin_x, fin_y, neg_x, neg_y;
  logic [32:0] delta_x, delta_y;
  logic [SIDE_BITS-1:0] side_x, side_y;
  logic [16:0] fmul;
  logic [49:0] side_prod;
  logic [STEP_BITS-1:0] nsteps;
  logic        side;
  logic        fault;
  logic [7:0]  code;
  logic [SIDE_BITS-1:0] dist_raw;
  logic        out_load;

  assign dreq.divisor = (state == S_DIVX) ? mag_x : mag_y;
  assign dreq.start   = (state == S_DIVX && fin_x) || (state == S_DIVY && fin_y);

  // fraction factor of initial side distance
  always_comb begin
    if (state == S_SIDEX)
      fmul = neg_x ? {1'b0, player_x[15:0]} : (17'h10000 - {1'b0, player_x[15:0]});
    else
      fmul = neg_y ? {1'b0, player_y[15:0]} : (17'h10000 - {1'b0, player_y[15:0]});
  end
  assign side_prod = {33'd0, fmul} * {17'd0, (state == S_SIDEX) ? delta_x : delta_y};

  logic step_x;
  assign step_x = fin_x && (!fin_y || side_x < side_y);
  assign dist_raw = side ? (side_y - {7'd0, delta_y}) : (side_x - {7'd0, delta_x});

  // result register loads once the previous word has left
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (accept && in_action) begin
          col <= in_scol;
          cx  <= 18'(({8'd0, in_scol} << 17) / SCREEN_COLUMNS) - 18'sd65536;
          state <= S_CX;
        end
        S_CX: begin
          prod_x <= plane_x * cx;
          prod_y <= plane_y * cx;
          state <= S_RAY;
        end
        S_RAY: begin
          ray_x <= 20'(dir_x) + 20'(prod_x >>> 16);
          ray_y <= 20'(dir_y) + 20'(prod_y >>> 16);
          state <= S_MAG;
        end
        // magnitudes and signs, ready before the divider starts
        S_MAG: begin
          neg_x <= ray_x[19];
          neg_y <= ray_y[19];
          mag_x <= 19'(ray_x[19] ? -ray_x : ray_x);
          mag_y <= 19'(ray_y[19] ? -ray_y : ray_y);
          fin_x <= (ray_x != 0);
          fin_y <= (ray_y != 0);
          state <= S_DIVX;
        end
        S_DIVX: state <= S_WAITX;
        S_WAITX: begin
          if (!fin_x) begin delta_x <= '0; state <= S_DIVY; end
          else if (drsp.done) begin delta_x <= drsp.quotient; state <= S_DIVY; end
        end
        S_DIVY: state <= S_WAITY;
        S_WAITY: begin
          if (!fin_y) begin delta_y <= '0; state <= S_SIDEX; end
          else if (drsp.done) begin delta_y <= drsp.quotient; state <= S_SIDEX; end
        end
        S_SIDEX: begin
          side_x <= SIDE_BITS'(side_prod >> 16);
          state <= S_SIDEY;
        end
        S_SIDEY: begin
          side_y <= SIDE_BITS'(side_prod >> 16);
          mx <= {2'b00, player_x[21:16]};
          my <= {2'b00, player_y[21:16]};
          nsteps <= '0;
          state <= S_STEP;
        end
        // one DDA step, then bounds check
        S_STEP: begin
          if (nsteps == STEP_BITS'(STEP_LIMIT)) begin
            fault <= 1'b1; state <= S_OUT;
          end else begin
            nsteps <= nsteps + 1'b1;
            if (step_x) begin
              side_x <= side_x + {7'd0, delta_x};
              mx <= neg_x ? mx - 8'sd1 : mx + 8'sd1;
              side <= 1'b0;
            end else begin
              side_y <= side_y + {7'd0, delta_y};
              my <= neg_y ? my - 8'sd1 : my + 8'sd1;
              side <= 1'b1;
            end
            state <= S_READ;
          end
        end
        S_READ: begin
          if (mx < 0 || my < 0 || mx >= MAP_SIDE || my >= MAP_SIDE) begin
            fault <= 1'b1; state <= S_OUT;
          end else state <= S_CHECK;
        end
        S_CHECK: begin
          code <= ram_rdata;
          if (ram_rdata != CODE_EMPTY && ram_rdata != CODE_OPEN) begin
            fault <= 1'b0; state <= S_OUT;
          end else state <= S_STEP;
        end
        S_OUT: if (out_load) begin
          m_tdata[9:0] <= col;
          if (fault) begin
            m_tdata[54:10] <= '0;
            m_tdata[55] <= 1'b1;
          end else begin
            m_tdata[33:10] <= (!(side ? fin_y : fin_x) || dist_raw > 40'hFFFFFF)
                              ? 24'hFFFFFF : dist_raw[23:0];
            m_tdata[34] <= side;
            m_tdata[40:35] <= mx[5:0];
            m_tdata[46:41] <= my[5:0];
            m_tdata[54:47] <= code;
            m_tdata[55] <= 1'b0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_IDLE && accept && in_action) fault <= 1'b1;
    end
  end

endmodule
